// File: sv/box_blur_3x3_rgb_top_defines.svh
// assertion helpers for the box blur top level
`ifndef BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BB_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bblur_pkg.sv
`timescale 1ns / 1ps
package bblur_pkg;

  // pixel and window geometry
  localparam int CH_BITS  = 8;
  localparam int NUM_CH   = 3;
  localparam int RGB_BITS = CH_BITS * NUM_CH;
  localparam int NUM_ROWS = 3;
  localparam int NUM_COLS = 3;

  // averaging datapath widths
  localparam int SUM_BITS    = 12;
  localparam int CNT_BITS    = 4;
  localparam int TERM_BITS   = SUM_BITS + 1;
  localparam int RECIP_BITS  = 20;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_BITS   = TERM_BITS + RECIP_BITS;

  // configuration port
  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int WIDTH_RESET     = 640;
  localparam int HEIGHT_RESET    = 480;

  // row and column selections, bit 0 is the top row or left column
  localparam logic [NUM_ROWS-1:0] MASK_ALL       = 3'b111;
  localparam logic [NUM_ROWS-1:0] MASK_LAST_TWO  = 3'b110;
  localparam logic [NUM_ROWS-1:0] MASK_LAST_ONE  = 3'b100;
  localparam logic [NUM_ROWS-1:0] MASK_FIRST_TWO = 3'b011;
  localparam logic [NUM_ROWS-1:0] MASK_MIDDLE    = 3'b010;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL,
    OP_FLUSH
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FLOAD,
    ST_CALC,
    ST_WAIT,
    ST_EMIT
  } state_t;

  typedef logic [NUM_CH-1:0][CH_BITS-1:0]   rgb_t;
  typedef rgb_t [NUM_ROWS-1:0]               column_t;
  typedef logic [NUM_CH-1:0][SUM_BITS-1:0]  rgb_sum_t;
  typedef logic [CNT_BITS-1:0]              count_t;

  typedef struct packed {
    logic                shift;
    logic [NUM_ROWS-1:0] row_use;
  } cell_ctrl_t;

  // ceil(2^RECIP_SHIFT / (2*n)) for the neighbour counts that occur
  function automatic logic [RECIP_BITS-1:0] recip_of(input count_t n);
    logic [RECIP_BITS-1:0] r;
    unique case (n)
      4'd1:    r = 20'd524288;
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd6:    r = 20'd87382;
      4'd9:    r = 20'd58255;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/bblur_if.sv
`timescale 1ns / 1ps
// pixel stream into the blur
interface bblur_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [bblur_pkg::RGB_BITS-1:0]    pixel_rgb;

  modport source (output valid, output op, output pixel_rgb, input ready);
  modport sink   (input valid, input op, input pixel_rgb, output ready);
endinterface

// blurred pixel stream out of the blur
interface bblur_out_if;
  logic                              valid;
  logic                              ready;
  logic [bblur_pkg::RGB_BITS-1:0]    blurred_rgb;
  logic                              frame_end;

  modport source (output valid, output blurred_rgb, output frame_end, input ready);
  modport sink   (input valid, input blurred_rgb, input frame_end, output ready);
endinterface

// File: sv/bblur_line_store.sv
`timescale 1ns / 1ps
module bblur_line_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output bblur_pkg::rgb_t     rd_older,
  output bblur_pkg::rgb_t     rd_newer,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  bblur_pkg::rgb_t     wr_older,
  input  bblur_pkg::rgb_t     wr_newer
);
  import bblur_pkg::*;

  rgb_t older_mem [DEPTH];
  rgb_t newer_mem [DEPTH];

  // two rows back
  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= wr_older;
    end
    if (rd_en) begin
      rd_older <= older_mem[rd_addr];
    end
  end

  // one row back
  always_ff @(posedge clk) begin
    if (wr_en) begin
      newer_mem[wr_addr] <= wr_newer;
    end
    if (rd_en) begin
      rd_newer <= newer_mem[rd_addr];
    end
  end

endmodule

// File: sv/bblur_cell.sv
`timescale 1ns / 1ps
module bblur_cell (
  input  logic                  clk,
  input  bblur_pkg::cell_ctrl_t ctrl,
  input  logic                  col_use,
  input  bblur_pkg::column_t    col_in,
  output bblur_pkg::column_t    col_out,
  input  bblur_pkg::rgb_sum_t   sum_in,
  input  bblur_pkg::count_t     cnt_in,
  output bblur_pkg::rgb_sum_t   sum_out,
  output bblur_pkg::count_t     cnt_out
);
  import bblur_pkg::*;

  column_t col;

  // one window column, passed on to the left neighbour on each shift
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

  // add this column's selected rows to the running sum from the right
  always_comb begin
    sum_out = sum_in;
    cnt_out = cnt_in;
    for (int rw = 0; rw < NUM_ROWS; rw++) begin
      if (col_use && ctrl.row_use[rw]) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          sum_out[ch] = sum_out[ch] + SUM_BITS'(col[rw][ch]);
        end
        cnt_out = cnt_out + CNT_BITS'(1);
      end
    end
  end

endmodule

// File: sv/bblur_mean.sv
`timescale 1ns / 1ps
module bblur_mean (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  bblur_pkg::rgb_sum_t sum,
  input  bblur_pkg::count_t   count,
  output logic                done,
  output bblur_pkg::rgb_t     mean
);
  import bblur_pkg::*;

  logic [NUM_CH-1:0][TERM_BITS-1:0] term;
  logic [RECIP_BITS-1:0]            recip;
  logic [NUM_CH-1:0][PROD_BITS-1:0] prod;
  logic                             term_valid;

  // two-stage valid track
  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      term_valid <= start;
      done       <= term_valid;
    end
  end

  // 2*sum + n and the reciprocal of 2*n
  always_ff @(posedge clk) begin
    if (start) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        term[ch] <= TERM_BITS'({sum[ch], 1'b0}) + TERM_BITS'(count);
      end
      recip <= recip_of(count);
    end
  end

  // reciprocal multiply, exact for every reachable term
  always_ff @(posedge clk) begin
    if (term_valid) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        prod[ch] <= PROD_BITS'(term[ch]) * PROD_BITS'(recip);
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      mean[ch] = prod[ch][RECIP_SHIFT +: CH_BITS];
    end
  end

endmodule

// File: sv/box_blur_3x3_rgb_top.sv
`timescale 1ns / 1ps
`include "box_blur_3x3_rgb_top_defines.svh"
// channel   | direction | payload                       | handshake
// pix_in    | in        | op, pixel_rgb                 | valid / ready
// blur_out  | out       | blurred_rgb, frame_end        | valid / ready
// cfg       | in        | cfg_index, cfg_data           | cfg_write_en, no wait
//
// one item at a time: a new item is taken only in the idle step, once the last one is done;
// a pixel yields no, one or two results and a flush item one result
// each item goes through the registered line store read, and the shared
// two-stage reciprocal divider is used once per result
// rst is synchronous and clears positions, flush state and handshakes
// a stalled output holds the block in its emit step; the next item still waits
// only for the block itself, not for the output to be taken
module box_blur_3x3_rgb_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_en,
  input  logic [bblur_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bblur_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  bblur_in_if.sink                             pix_in,
  bblur_out_if.source                          blur_out
);
  import bblur_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WLAST_RST = ((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET) - 1;
  localparam int HLAST_RST = ((HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET) - 1;

  state_t             state, state_next;
  logic [COL_W-1:0]   wlast, wlast_new;
  logic [ROW_W-1:0]   hlast, hlast_new;
  logic [31:0]        width_req, height_req;
  logic [COL_W-1:0]   col, flush_col, flush_lo;
  logic [ROW_W-1:0]   row;
  logic               flushing;
  logic               accept, px_go, fl_go;

  logic [COL_W-1:0]    item_col, fcol, f_hi;
  logic [1:0]          fcnt;
  rgb_t                px_reg;
  logic                want_a, want_b, sel_b, frame_end_r;
  logic [NUM_ROWS-1:0] row_use_r;
  logic [NUM_COLS-1:0] cols_a, cols_b, col_sel;

  logic               rd_en, shift, mean_start, emit, out_free;
  logic [COL_W-1:0]   rd_addr;
  rgb_t               rd_older, rd_newer;
  column_t            new_col;
  cell_ctrl_t         cell_ctrl;
  column_t            chain_col [NUM_COLS+1];
  rgb_sum_t           chain_sum [NUM_COLS+1];
  count_t             chain_cnt [NUM_COLS+1];
  logic               mean_done;
  rgb_t               mean;

  logic               out_valid, out_frame_end;
  rgb_t               out_rgb;

  // clamp requested frame size to 1..MAX
  assign width_req  = 32'(cfg_data[CFG_WIDTH_BITS-1:0]);
  assign height_req = 32'(cfg_data[CFG_HEIGHT_BITS-1:0]);

  always_comb begin
    if (width_req == 32'd0) begin
      wlast_new = '0;
    end else if (width_req > 32'(MAX_WIDTH)) begin
      wlast_new = COL_W'(MAX_WIDTH - 1);
    end else begin
      wlast_new = COL_W'(width_req - 32'd1);
    end
    if (height_req == 32'd0) begin
      hlast_new = '0;
    end else if (height_req > 32'(MAX_HEIGHT)) begin
      hlast_new = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hlast_new = ROW_W'(height_req - 32'd1);
    end
  end

  // item classification
  assign pix_in.ready = (state == ST_IDLE);
  assign accept       = pix_in.valid && (state == ST_IDLE);
  assign px_go        = accept && (op_t'(pix_in.op) == OP_PIXEL) && !flushing;
  assign fl_go        = accept && (op_t'(pix_in.op) == OP_FLUSH) && flushing;
  assign flush_lo     = (flush_col != '0) ? flush_col - COL_W'(1) : '0;

  // frame size, raster position and flush position
  always_ff @(posedge clk) begin
    if (rst) begin
      wlast     <= COL_W'(WLAST_RST);
      hlast     <= ROW_W'(HLAST_RST);
      col       <= '0;
      row       <= '0;
      flush_col <= '0;
      flushing  <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  wlast <= wlast_new;
        REG_FRAME_HEIGHT: hlast <= hlast_new;
      endcase
      col       <= '0;
      row       <= '0;
      flush_col <= '0;
      flushing  <= 1'b0;
    end else if (px_go) begin
      if (col == wlast) begin
        col <= '0;
        if (row == hlast) begin
          row       <= '0;
          flushing  <= 1'b1;
          flush_col <= '0;
        end else begin
          row <= row + ROW_W'(1);
        end
      end else begin
        col <= col + COL_W'(1);
      end
    end else if (fl_go) begin
      if (flush_col == wlast) begin
        col       <= '0;
        row       <= '0;
        flush_col <= '0;
        flushing  <= 1'b0;
      end else begin
        flush_col <= flush_col + COL_W'(1);
      end
    end
  end

  // per-item window selections, captured at acceptance
  always_ff @(posedge clk) begin
    if (px_go) begin
      item_col  <= col;
      px_reg    <= pix_in.pixel_rgb;
      row_use_r <= (row > ROW_W'(1)) ? MASK_ALL : MASK_LAST_TWO;
      cols_a    <= (col > COL_W'(1)) ? MASK_ALL : MASK_LAST_TWO;
      cols_b    <= (wlast != '0) ? MASK_LAST_TWO : MASK_LAST_ONE;
    end else if (fl_go) begin
      fcol      <= flush_col;
      f_hi      <= (flush_col != wlast) ? flush_col + COL_W'(1) : flush_col;
      row_use_r <= (hlast != '0) ? MASK_FIRST_TWO : MASK_MIDDLE;
      cols_a    <= {flush_col != wlast, 1'b1, flush_col != '0};
    end
  end

  // result bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      want_a      <= 1'b0;
      want_b      <= 1'b0;
      sel_b       <= 1'b0;
      frame_end_r <= 1'b0;
      fcnt        <= '0;
    end else begin
      if (px_go) begin
        want_a      <= (row != '0) && (col != '0);
        want_b      <= (row != '0) && (col == wlast);
        frame_end_r <= 1'b0;
      end else if (fl_go) begin
        want_a      <= 1'b1;
        want_b      <= 1'b0;
        frame_end_r <= (flush_col == wlast);
        fcnt        <= '0;
      end
      if (state == ST_FLOAD) begin
        fcnt  <= fcnt + 2'd1;
        sel_b <= 1'b0;
      end
      if (state == ST_LOAD) begin
        sel_b <= !want_a;
      end
      if (emit) begin
        sel_b <= 1'b1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = col;
    shift      = 1'b0;
    mean_start = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        rd_en   = pix_in.valid;
        rd_addr = (op_t'(pix_in.op) == OP_FLUSH) ? flush_lo : col;
        if (px_go) begin
          state_next = ST_LOAD;
        end else if (fl_go) begin
          state_next = ST_FLOAD;
        end
      end
      ST_LOAD: begin
        shift      = 1'b1;
        state_next = (want_a || want_b) ? ST_CALC : ST_IDLE;
      end
      ST_FLOAD: begin
        shift   = 1'b1;
        rd_en   = (fcnt != 2'd2);
        rd_addr = (fcnt == 2'd0) ? fcol : f_hi;
        if (fcnt == 2'd2) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        mean_start = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (mean_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = (!sel_b && want_b) ? ST_CALC : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // two line stores; the old newer row moves to the older store
  bblur_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_store (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_older (rd_older),
    .rd_newer (rd_newer),
    .wr_en    (state == ST_LOAD),
    .wr_addr  (item_col),
    .wr_older (rd_newer),
    .wr_newer (px_reg)
  );

  // window of three column cells, new column enters on the right
  assign new_col[0]          = rd_older;
  assign new_col[1]          = rd_newer;
  assign new_col[2]          = px_reg;
  assign chain_col[NUM_COLS] = new_col;
  assign chain_sum[NUM_COLS] = '0;
  assign chain_cnt[NUM_COLS] = '0;
  assign cell_ctrl.shift     = shift;
  assign cell_ctrl.row_use   = row_use_r;
  assign col_sel             = sel_b ? cols_b : cols_a;

  for (genvar i = 0; i < NUM_COLS; i++) begin : g_cell
    bblur_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .col_use (col_sel[i]),
      .col_in  (chain_col[i+1]),
      .col_out (chain_col[i]),
      .sum_in  (chain_sum[i+1]),
      .cnt_in  (chain_cnt[i+1]),
      .sum_out (chain_sum[i]),
      .cnt_out (chain_cnt[i])
    );
  end

  // rounded mean of the selected neighbours
  bblur_mean u_mean (
    .clk   (clk),
    .rst   (rst),
    .start (mean_start),
    .sum   (chain_sum[0]),
    .count (chain_cnt[0]),
    .done  (mean_done),
    .mean  (mean)
  );

  // output register
  assign out_free = !out_valid || blur_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (blur_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_rgb       <= mean;
      out_frame_end <= frame_end_r;
    end
  end

  assign blur_out.valid       = out_valid;
  assign blur_out.blurred_rgb = out_rgb;
  assign blur_out.frame_end   = out_frame_end;

  // checks
  `BB_ASSERT_NOW(a_done_in_wait, clk, rst, mean_done, state == ST_WAIT, "divider result outside wait step")
  `BB_ASSERT_NOW(a_count_nonzero, clk, rst, state == ST_CALC, chain_cnt[0] != '0, "empty neighbourhood")
  `BB_ASSERT_NOW(a_flush_pos_zero, clk, rst, flushing, (col == '0) && (row == '0), "raster position moved while flushing")
  `BB_ASSERT_NEXT(a_frame_to_flush, clk, rst, px_go && (col == wlast) && (row == hlast), flushing, "last pixel did not start flush")

endmodule

// File: bench/tb_box_blur_3x3_rgb_top.sv
`timescale 1ns / 1ps
module tb_box_blur_3x3_rgb_top;
  import bblur_pkg::*;

  localparam int MAX_W           = 1024;
  localparam int MAX_H           = 4096;
  localparam int QUIET_CYCLES    = 24;
  localparam int STALL_LIMIT     = 3000;
  localparam int RANDOM_ITEMS    = 1550;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_PRINTED     = 50;

  typedef struct packed {
    rgb_t rgb;
    logic frame_end;
  } blur_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    cfg_reg_t                  reg_sel;
    logic [CFG_DATA_BITS-1:0]  reg_value;
    op_t                       op;
    rgb_t                      pixel;
    logic                      known;
    rgb_t                      known_rgb;
    logic                      known_end;
  } dir_row_t;

  typedef logic [NUM_CH-1:0][15:0] chan_sums_t;

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  bblur_in_if  pix_if ();
  bblur_out_if blur_if ();

  box_blur_3x3_rgb_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pix_in       (pix_if),
    .blur_out     (blur_if)
  );

  // blurred pixels still owed by the block, oldest first
  blur_result_t blur_expected [$];

  int error_count = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int hold_left = 0;

  // shadow of the block's line stores, window and frame position
  rgb_t older_line [MAX_W];
  rgb_t newer_line [MAX_W];
  rgb_t win [9];
  int   in_row;
  int   in_col;
  int   flush_col;
  bit   flushing;
  logic [CFG_WIDTH_BITS-1:0]  width_reg;
  logic [CFG_HEIGHT_BITS-1:0] height_reg;

  // directed stimulus: corner sizes, rounding, ignored items, register saturation
  dir_row_t directed_rows [35] = '{
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'hFFFFFF, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_FLUSH, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_FRAME_WIDTH,  13'h0001, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'h0001, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'h123456, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'hFFFFFF, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_FLUSH, 24'h000000, 1'b1, 24'h123456, 1'b1},
    '{ROW_WRITE, REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'h0000, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'hFFFFFF, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_FLUSH, 24'h000000, 1'b1, 24'hFFFFFF, 1'b1},
    '{ROW_WRITE, REG_FRAME_WIDTH,  13'h0002, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'h0001, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'h010101, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_FLUSH, 24'h000000, 1'b1, 24'h010101, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_FLUSH, 24'h000000, 1'b1, 24'h010101, 1'b1},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'h0002, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'hFFFFFF, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'h00FF00, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'h80FF01, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'h7F00FE, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_FLUSH, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_FLUSH, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_FRAME_WIDTH,  13'h1FFF, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'h1FFF, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'hABCDEF, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'h543210, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_FLUSH, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_FRAME_WIDTH,  13'h0001, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 13'h1000, OP_PIXEL, 24'h000000, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'hFFFFFF, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'h000001, 1'b0, 24'h0, 1'b0},
    '{ROW_ITEM,  REG_FRAME_WIDTH,  13'h0000, OP_PIXEL, 24'h020304, 1'b0, 24'h0, 1'b0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // effective sizes after clamping to 1..max
  function automatic int eff_width();
    if (width_reg == '0) return 1;
    if (int'(width_reg) > MAX_W) return MAX_W;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg == '0) return 1;
    if (int'(height_reg) > MAX_H) return MAX_H;
    return int'(height_reg);
  endfunction

  function automatic void restart_frame();
    in_row = 0;
    in_col = 0;
    flush_col = 0;
    flushing = 1'b0;
  endfunction

  function automatic chan_sums_t add_channels(input chan_sums_t sums, input rgb_t px);
    chan_sums_t acc;
    acc = sums;
    for (int ch = 0; ch < NUM_CH; ch++) acc[ch] += 16'(px[ch]);
    return acc;
  endfunction

  // per channel mean, rounded half up
  function automatic rgb_t rounded_mean(input chan_sums_t sums, input int cnt);
    rgb_t res;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      res[ch] = 8'((2 * int'(sums[ch]) + cnt) / (2 * cnt));
    end
    return res;
  endfunction

  // mean over window rows first_row..2 and columns first_col..2
  function automatic rgb_t window_average(input int first_row, input int first_col);
    chan_sums_t sums;
    int cnt;
    sums = '0;
    cnt = 0;
    for (int r = first_row; r < NUM_ROWS; r++) begin
      for (int c = first_col; c < NUM_COLS; c++) begin
        sums = add_channels(sums, win[r * NUM_COLS + c]);
        cnt++;
      end
    end
    return rounded_mean(sums, cnt);
  endfunction

  // advance the shadow state by one accepted item, queue the blurred pixels it yields
  function automatic int predict_blur(input op_t op, input rgb_t px);
    int w;
    int h;
    int c;
    int r;
    int f;
    int lo;
    int hi;
    int first_row;
    int cnt;
    int produced;
    chan_sums_t sums;
    blur_result_t res;
    w = eff_width();
    h = eff_height();
    produced = 0;
    if (op == OP_PIXEL) begin
      if (flushing) return 0;
      c = in_col;
      r = in_row;
      if (c >= w) c = w - 1;
      // slide the window left and load the new right-hand column
      for (int k = 0; k < NUM_ROWS; k++) begin
        win[k * 3] = win[k * 3 + 1];
        win[k * 3 + 1] = win[k * 3 + 2];
      end
      win[2] = older_line[c];
      win[5] = newer_line[c];
      win[8] = px;
      older_line[c] = newer_line[c];
      newer_line[c] = px;
      first_row = (r >= 2) ? 0 : 1;
      res.frame_end = 1'b0;
      if (r >= 1 && c >= 1) begin
        res.rgb = window_average(first_row, (c >= 2) ? 0 : 1);
        blur_expected.push_back(res);
        produced++;
      end
      // row end also closes out the last column of the row above
      if (c >= w - 1) begin
        if (r >= 1) begin
          res.rgb = window_average(first_row, (w >= 2) ? 1 : 2);
          blur_expected.push_back(res);
          produced++;
        end
        in_col = 0;
        if (r >= h - 1) begin
          in_row = 0;
          flushing = 1'b1;
          flush_col = 0;
        end else begin
          in_row = r + 1;
        end
      end else begin
        in_col = c + 1;
      end
    end else begin
      if (!flushing) return 0;
      f = flush_col;
      if (f >= w) f = w - 1;
      lo = (f >= 1) ? f - 1 : 0;
      hi = (f + 1 < w) ? f + 1 : f;
      sums = '0;
      cnt = 0;
      // last row: neighbours from the two stored rows only
      for (int col = lo; col <= hi; col++) begin
        if (h >= 2) begin
          sums = add_channels(sums, older_line[col]);
          cnt++;
        end
        sums = add_channels(sums, newer_line[col]);
        cnt++;
      end
      res.rgb = rounded_mean(sums, cnt);
      res.frame_end = (f >= w - 1);
      blur_expected.push_back(res);
      produced = 1;
      if (f >= w - 1) begin
        restart_frame();
      end else begin
        flush_col = f + 1;
      end
    end
    return produced;
  endfunction

  function automatic rgb_t random_pixel();
    rgb_t px;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      case ($urandom_range(9))
        0: px[ch] = 8'h00;
        1: px[ch] = 8'hFF;
        default: px[ch] = 8'($urandom);
      endcase
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("mismatch: %s got %h want %h at %0t", what, got, want, $realtime);
    end
    error_count++;
  endtask

  // one transaction on the pixel channel, with a random gap before it
  task automatic send_item(input op_t op, input rgb_t px, input logic known = 1'b0,
                           input rgb_t known_rgb = '0, input logic known_end = 1'b0);
    int produced;
    blur_result_t typed;
    while ($urandom_range(99) < in_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.op <= op;
    pix_if.pixel_rgb <= px;
    do @(posedge clk); while (!pix_if.ready);
    produced = predict_blur(op, px);
    if (known && produced > 0) begin
      typed.rgb = known_rgb;
      typed.frame_end = known_end;
      blur_expected[blur_expected.size() - 1] = typed;
    end
  endtask

  // stop offering and let every owed result and any silent item finish
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t sel, input logic [CFG_DATA_BITS-1:0] value);
    drain_results();
    cfg_write_en <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    if (sel == REG_FRAME_WIDTH) begin
      width_reg = value[CFG_WIDTH_BITS-1:0];
    end else begin
      height_reg = value[CFG_HEIGHT_BITS-1:0];
    end
    restart_frame();
  endtask

  // output side: random stalls, plus a long hold-off on request
  initial begin
    blur_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        blur_if.ready <= 1'b0;
      end else begin
        blur_if.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // compare each blurred transaction with the oldest owed result
  always @(posedge clk) begin : check_blur
    blur_result_t want;
    if (!rst && blur_if.valid === 1'b1 && blur_if.ready === 1'b1) begin
      if (blur_expected.size() == 0) begin
        report_mismatch("result with none pending", 32'(blur_if.blurred_rgb), '0);
      end else begin
        want = blur_expected.pop_front();
        if (blur_if.blurred_rgb !== want.rgb) begin
          report_mismatch("blurred_rgb", 32'(blur_if.blurred_rgb), 32'(want.rgb));
        end
        if (blur_if.frame_end !== want.frame_end) begin
          report_mismatch("frame_end", 32'(blur_if.frame_end), 32'(want.frame_end));
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (pix_if.valid && pix_if.ready) || (blur_if.valid && blur_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    int items_sent;
    int frame_no;
    int pick;
    int w;
    int h;
    int total;
    int npix;
    bit frame_open;
    bit wide_run;
    bit wide_done;
    bit pressure;
    logic [CFG_DATA_BITS-1:0] width_val;
    logic [CFG_DATA_BITS-1:0] height_val;

    rst <= 1'b1;
    cfg_write_en <= 1'b0;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= '0;
    pix_if.valid <= 1'b0;
    pix_if.op <= OP_PIXEL;
    pix_if.pixel_rgb <= '0;

    // shadow state at reset
    for (int i = 0; i < MAX_W; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) win[i] = '0;
    width_reg = CFG_WIDTH_BITS'(WIDTH_RESET);
    height_reg = CFG_HEIGHT_BITS'(HEIGHT_RESET);
    restart_frame();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_register(directed_rows[i].reg_sel, directed_rows[i].reg_value);
      end else begin
        send_item(directed_rows[i].op, directed_rows[i].pixel, directed_rows[i].known,
                  directed_rows[i].known_rgb, directed_rows[i].known_end);
      end
    end

    // random frames, mostly well formed, with stray and aborted sequences
    items_sent = 0;
    frame_no = 0;
    frame_open = 1'b1;
    wide_done = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      case (frame_no % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 73; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 73; end
        default: begin in_idle_pct = 11; out_stall_pct = 11; end
      endcase
      wide_run = !wide_done && items_sent >= 400;
      pressure = (frame_no == 5);

      if (frame_open || wide_run || pressure || $urandom_range(99) < 50) begin
        pick = $urandom_range(99);
        width_val = CFG_DATA_BITS'($urandom_range(1, 6));
        height_val = CFG_DATA_BITS'($urandom_range(1, 4));
        if (wide_run) begin
          width_val = CFG_DATA_BITS'(MAX_W);
          height_val = CFG_DATA_BITS'(2);
        end else if (pressure) begin
          width_val = CFG_DATA_BITS'(8);
          height_val = CFG_DATA_BITS'(4);
        end else if (pick < 20) begin
          width_val = CFG_DATA_BITS'($urandom_range(7, 24));
        end else if (pick < 30) begin
          height_val = CFG_DATA_BITS'($urandom_range(5, 9));
        end else if (pick < 34) begin
          width_val = '0;
        end else if (pick < 38) begin
          height_val = '0;
        end else if (pick < 42) begin
          height_val = CFG_DATA_BITS'($urandom_range(MAX_H + 1, 8191));
        end else if (pick < 45) begin
          width_val = CFG_DATA_BITS'($urandom_range(MAX_W + 1, 8191));
        end else if (pick < 50) begin
          // bits above the width field are dropped by the block
          width_val[CFG_DATA_BITS-1:CFG_WIDTH_BITS] = 2'($urandom_range(1, 3));
        end
        write_register(REG_FRAME_WIDTH, width_val);
        write_register(REG_FRAME_HEIGHT, height_val);
      end else if ($urandom_range(99) < 10) begin
        drain_results();
      end

      // long output hold-off while the input keeps offering
      if (pressure) begin
        in_idle_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
      end

      w = eff_width();
      h = eff_height();
      total = w * h;
      npix = total;
      if (wide_run) begin
        npix = MAX_W + 6;
        wide_done = 1'b1;
      end else if (total > 250) begin
        npix = $urandom_range(1, 60);
      end else if ($urandom_range(99) < 8) begin
        npix = $urandom_range(0, total - 1);
      end

      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(99) < 3) send_item(OP_FLUSH, random_pixel());
        send_item(OP_PIXEL, random_pixel());
        items_sent++;
      end
      frame_open = (npix < total);

      // last row out, with the odd stray pixel and an occasional early stop
      if (!frame_open) begin
        for (int f = 0; f < w; f++) begin
          if ($urandom_range(99) < 4) send_item(OP_PIXEL, random_pixel());
          if ($urandom_range(99) < 2) begin
            frame_open = 1'b1;
            break;
          end
          send_item(OP_FLUSH, random_pixel());
          items_sent++;
        end
      end

      if (pressure) drain_results();
      frame_no++;
    end

    // wind down with the output always ready
    out_stall_pct = 0;
    hold_left = 0;
    drain_results();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
